### rtl/mdvc_pkg.sv
`default_nettype none

package mdvc_pkg;

	localparam int CHANNELS   = 12;
	localparam int SAMPLE_MAX = 4095;

	localparam int SAMPLE_W = 12;
	localparam int SUM_W    = SAMPLE_W + 1;
	localparam int TH_W     = 8;
	localparam int CNT_W    = 7;
	localparam int FIELD_W  = 12;
	localparam int REG_W    = 48;
	localparam int IDX_W    = 3;

	localparam int SP_PER_REG = REG_W / SAMPLE_W;
	localparam int TH_PER_REG = REG_W / TH_W;

	localparam int IN_W  = CHANNELS * SAMPLE_W;
	localparam int IN_TW = ((IN_W + 7) / 8) * 8;
	localparam int OUT_W = 3 * FIELD_W + 1;
	localparam int OUT_TW = ((OUT_W + 7) / 8) * 8;

	// tdata field offsets on the result side
	localparam int OFS_FILL   = 0;
	localparam int OFS_VENT   = FIELD_W;
	localparam int OFS_STABLE = 2 * FIELD_W;
	localparam int OFS_ALL    = 3 * FIELD_W;

	localparam logic [SUM_W-1:0] SAMPLE_MAX_V = SUM_W'(SAMPLE_MAX);

	localparam logic [IDX_W-1:0] REG_SP_LOW    = 3'd0;
	localparam logic [IDX_W-1:0] REG_SP_MID    = 3'd1;
	localparam logic [IDX_W-1:0] REG_SP_HIGH   = 3'd2;
	localparam logic [IDX_W-1:0] REG_TH_LOW    = 3'd3;
	localparam logic [IDX_W-1:0] REG_TH_HIGH   = 3'd4;
	localparam logic [IDX_W-1:0] REG_ENABLE    = 3'd5;
	localparam logic [IDX_W-1:0] REG_STABLE_CNT = 3'd6;

	localparam logic [REG_W-1:0]    SP_RESET  = 48'h800800800800;
	localparam logic [REG_W-1:0]    TH_RESET  = 48'hC8C8C8C8C8C8;
	localparam logic [CHANNELS-1:0] EN_RESET  = '0;
	localparam logic [CNT_W-1:0]    CNT_RESET = 7'd100;

endpackage

`default_nettype wire

### rtl/multichannel_deadband_valve_control.sv
`default_nettype none

// Channel  Handshake                    Payload
// s_axis   s_axis_tvalid/s_axis_tready  s_axis_tdata: sample_0 .. sample_11
// m_axis   m_axis_tvalid/m_axis_tready  m_axis_tdata: fill_valves, vent_valves,
//                                       stable_bits, all_stable
// cfg      cfg_we                       cfg_index, cfg_data
//
// One scan per cycle sustained while m_axis_tready holds; a scan passes the input register, then the result register.
// The band compare and counter update for all channels sit between those two registers.
// arst_n clears valves, counters, stable mask and loads the register defaults.
// A stalled result holds the result register; the input stage takes one more scan only if it is empty.

module multichannel_deadband_valve_control (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_axis_tvalid,
	output      logic                          s_axis_tready,
	// sample_0 .. sample_11, 12 bits each, channel 0 lowest
	input  wire logic [mdvc_pkg::IN_TW-1:0]    s_axis_tdata,
	output      logic                          m_axis_tvalid,
	input  wire logic                          m_axis_tready,
	// fill_valves[11:0], vent_valves[23:12], stable_bits[35:24], all_stable[36], zero pad
	output      logic [mdvc_pkg::OUT_TW-1:0]   m_axis_tdata,
	input  wire logic                          cfg_we,
	input  wire logic [mdvc_pkg::IDX_W-1:0]    cfg_index,
	input  wire logic [mdvc_pkg::REG_W-1:0]    cfg_data
);

	localparam int CH = mdvc_pkg::CHANNELS;

	logic [mdvc_pkg::REG_W-1:0]  sp_low_q, sp_mid_q, sp_high_q;
	logic [mdvc_pkg::REG_W-1:0]  th_low_q, th_high_q;
	logic [CH-1:0]               enable_q;
	logic [mdvc_pkg::CNT_W-1:0]  need_q;

	logic                        valid_s1;
	logic [mdvc_pkg::IN_W-1:0]   data_s1;
	logic                        advance;

	logic [mdvc_pkg::CNT_W-1:0]  cnt_q  [CH];
	logic [mdvc_pkg::CNT_W-1:0]  cnt_nx [CH];
	logic [CH-1:0]               stable_q, fill_q, vent_q;
	logic [CH-1:0]               stable_nx, fill_nx, vent_nx;
	logic                        all_nx;

	logic                        out_valid_q;
	logic [mdvc_pkg::OUT_W-1:0]  out_data_q;

	logic [3*mdvc_pkg::REG_W-1:0] sp_all;
	logic [2*mdvc_pkg::REG_W-1:0] th_all;

	assign sp_all = {sp_high_q, sp_mid_q, sp_low_q};
	assign th_all = {th_high_q, th_low_q};

	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_low_q  <= mdvc_pkg::SP_RESET;
			sp_mid_q  <= mdvc_pkg::SP_RESET;
			sp_high_q <= mdvc_pkg::SP_RESET;
			th_low_q  <= mdvc_pkg::TH_RESET;
			th_high_q <= mdvc_pkg::TH_RESET;
			enable_q  <= mdvc_pkg::EN_RESET;
			need_q    <= mdvc_pkg::CNT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				mdvc_pkg::REG_SP_LOW:     sp_low_q  <= cfg_data;
				mdvc_pkg::REG_SP_MID:     sp_mid_q  <= cfg_data;
				mdvc_pkg::REG_SP_HIGH:    sp_high_q <= cfg_data;
				mdvc_pkg::REG_TH_LOW:     th_low_q  <= cfg_data;
				mdvc_pkg::REG_TH_HIGH:    th_high_q <= cfg_data;
				mdvc_pkg::REG_ENABLE:     enable_q  <= cfg_data[CH-1:0];
				mdvc_pkg::REG_STABLE_CNT: need_q    <= cfg_data[mdvc_pkg::CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			data_s1 <= s_axis_tdata[mdvc_pkg::IN_W-1:0];
		end
	end

	// per-channel band decision
	always_comb begin
		logic [mdvc_pkg::SAMPLE_W-1:0] sp, smp;
		logic [mdvc_pkg::TH_W-1:0]     th;
		logic [mdvc_pkg::SUM_W-1:0]    lo, hi, s_ext;
		logic [mdvc_pkg::CNT_W-1:0]    inc;
		logic                          hold, below, above, quiet, hit;
		stable_nx = stable_q;
		fill_nx   = fill_q;
		vent_nx   = vent_q;
		for (int c = 0; c < CH; c++) begin
			sp    = sp_all[c*mdvc_pkg::SAMPLE_W +: mdvc_pkg::SAMPLE_W];
			th    = th_all[c*mdvc_pkg::TH_W +: mdvc_pkg::TH_W];
			smp   = data_s1[c*mdvc_pkg::SAMPLE_W +: mdvc_pkg::SAMPLE_W];
			s_ext = {1'b0, smp};
			lo    = {1'b0, sp} - mdvc_pkg::SUM_W'(th);
			hi    = {1'b0, sp} + mdvc_pkg::SUM_W'(th);
			hold  = (mdvc_pkg::SUM_W'(th) > {1'b0, sp}) || (hi > mdvc_pkg::SAMPLE_MAX_V);
			below = !hold && (s_ext < lo);
			above = !hold && !below && (s_ext > hi);
			quiet = !below && !above;
			inc   = cnt_q[c] + 1'b1;
			hit   = inc >= need_q;
			cnt_nx[c] = cnt_q[c];
			if (enable_q[c]) begin
				fill_nx[c] = below;
				vent_nx[c] = above;
				if (quiet) begin
					cnt_nx[c] = hit ? '0 : inc;
					if (hit) begin
						stable_nx[c] = 1'b1;
					end
				end else begin
					cnt_nx[c]    = '0;
					stable_nx[c] = 1'b0;
				end
			end
		end
		all_nx = (stable_nx == enable_q) && (enable_q != '0);
	end

	// channel state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stable_q <= '0;
			fill_q   <= '0;
			vent_q   <= '0;
			for (int c = 0; c < CH; c++) begin
				cnt_q[c] <= '0;
			end
		end else if (advance) begin
			stable_q <= all_nx ? '0 : stable_nx;
			fill_q   <= fill_nx;
			vent_q   <= vent_nx;
			for (int c = 0; c < CH; c++) begin
				cnt_q[c] <= cnt_nx[c];
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q <= {all_nx,
				mdvc_pkg::FIELD_W'(stable_nx),
				mdvc_pkg::FIELD_W'(vent_nx),
				mdvc_pkg::FIELD_W'(fill_nx)};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = mdvc_pkg::OUT_TW'(out_data_q);

endmodule

`default_nettype wire

### rtl/mdvc_checker.sv
`default_nettype none

module mdvc_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          s_axis_tvalid,
	input wire logic                          s_axis_tready,
	input wire logic                          m_axis_tvalid,
	input wire logic                          m_axis_tready,
	input wire logic [mdvc_pkg::OUT_TW-1:0]   m_axis_tdata
);

	logic [mdvc_pkg::FIELD_W-1:0] fill_v, vent_v, stable_v;
	logic                         all_v;

	assign fill_v   = m_axis_tdata[mdvc_pkg::OFS_FILL +: mdvc_pkg::FIELD_W];
	assign vent_v   = m_axis_tdata[mdvc_pkg::OFS_VENT +: mdvc_pkg::FIELD_W];
	assign stable_v = m_axis_tdata[mdvc_pkg::OFS_STABLE +: mdvc_pkg::FIELD_W];
	assign all_v    = m_axis_tdata[mdvc_pkg::OFS_ALL];

	// held result
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	a_valves: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (fill_v & vent_v) == '0)
		else $error("fill and vent open together");

	a_all: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && all_v |-> stable_v != '0)
		else $error("all_stable with empty stable mask");

	// a rising result valid must follow an input transfer through the input and result registers
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
		else $error("result without matching input transfer");

endmodule

bind multichannel_deadband_valve_control mdvc_checker u_mdvc_checker (.*);

`default_nettype wire
